[design/kms_pkg.sv]
`timescale 1ns / 1ps
package kms_pkg;

	localparam int ROWS   = 5;
	localparam int COLS   = 6;
	localparam int LAYERS = 4;
	localparam int CELLS  = LAYERS * ROWS * COLS;
	localparam int CELL_W = $clog2(CELLS);

	localparam int LAYER_W = 2;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 3;
	localparam int CODE_W  = 8;
	localparam int PIN_W   = 16;

	localparam int COL_BASE = 8;
	localparam logic [PIN_W-1:0]  FAIL_WORD   = 16'hFFFF;
	localparam logic [CODE_W-1:0] SPECIAL_MAX = 8'd5;

	localparam logic FUNC_SCAN = 1'b0;
	localparam logic FUNC_MAP  = 1'b1;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_SCAN_EN   = 2'd0;
	localparam logic [1:0] REG_LAYER_KEY = 2'd1;
	localparam logic [1:0] REG_NULL_KEY  = 2'd2;

	localparam logic [CODE_W-1:0] LAYER_KEY_RST = 8'd200;
	localparam logic [CODE_W-1:0] NULL_KEY_RST  = 8'd0;

	function automatic logic [CELL_W-1:0] cell_of(
		input logic [LAYER_W-1:0] lay,
		input logic [ROW_W-1:0]   row,
		input logic [COL_W-1:0]   col
	);
		cell_of = CELL_W'((int'(lay) * ROWS + int'(row)) * COLS + int'(col));
	endfunction

endpackage

[design/kms_ram.sv]
`timescale 1ns / 1ps
module kms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/key_matrix_scanner_with_layers.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  func, pin_word, map_layer, map_row, map_col, map_code
// out      out  out_valid/ out_stall key_code, is_press, layer, last
// cfg      in   APB psel/penable     paddr, pwdata, pwrite -> prdata, pready
//
// A scan transaction shifts the columns out one per ST_RD/ST_EV state pair, a keymap
// RAM read then its evaluation, then ends in a closing ST_FLUSH state.
// Keymap writes, failed reads and transactions while scanning is off complete in ST_IDLE.
// A held output stall holds a column or the closing state while a pending event
// waits for the output register.
// Reset clears the counters, then a clearing pass over all CELLS (120) entries zeroes the
// keymap and the pressed map; input stalls until it ends.
module key_matrix_scanner_with_layers
	import kms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [PIN_W-1:0]     pin_word,
	input  logic [LAYER_W-1:0]   map_layer,
	input  logic [ROW_W-1:0]     map_row,
	input  logic [COL_W-1:0]     map_col,
	input  logic [CODE_W-1:0]    map_code,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CODE_W-1:0]    key_code,
	output logic                 is_press,
	output logic [LAYER_W-1:0]   layer,
	output logic                 last,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EV, ST_FLUSH, ST_CLR} state_t;

	state_t              state_q;
	logic                scan_en_q;
	logic [CODE_W-1:0]   layer_key_q;
	logic [CODE_W-1:0]   null_key_q;
	logic [ROW_W-1:0]    row_q;
	logic [LAYER_W-1:0]  layer_q;
	logic [COL_W-1:0]    col_q;
	logic [COLS-1:0]     cols_q;
	logic [CELL_W-1:0]   clr_q;

	logic                pend_q;
	logic [CODE_W-1:0]   pcode_q;
	logic                ppress_q;
	logic [LAYER_W-1:0]  player_q;

	logic                out_valid_q;
	logic [CODE_W-1:0]   key_code_q;
	logic                is_press_q;
	logic [LAYER_W-1:0]  layer_out_q;
	logic                last_q;

	logic                in_fire;
	logic                out_fire;
	logic                out_busy;
	logic                clearing;
	logic                map_ok;
	logic [CELL_W-1:0]   waddr;
	logic                km_we;
	logic [CELL_W-1:0]   km_waddr;
	logic [CODE_W-1:0]   km_wdata;
	logic                pm_we;
	logic [CELL_W-1:0]   pm_waddr;
	logic                pm_wdata;
	logic                pm_rdata;
	logic [CELL_W-1:0]   cur_cell;
	logic [CELL_W-1:0]   upd_cell;
	logic [CODE_W-1:0]   rdata;
	logic [CODE_W-1:0]   code;
	logic                now_b;
	logic                change;
	logic                special;
	logic                is_layer;
	logic                is_null;
	logic                evt;
	logic                blocked;
	logic                out_load;
	logic                out_last;
	logic [LAYER_W-1:0]  new_lay;
	logic [ROW_W-1:0]    row_next;
	logic                col_last;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign out_busy = out_valid_q && out_stall;
	assign clearing = (state_q == ST_CLR);

	assign map_ok = (int'(map_layer) < LAYERS) && (int'(map_row) < ROWS)
		&& (int'(map_col) < COLS);
	assign waddr  = cell_of(map_layer, map_row, map_col);

	assign km_we    = clearing || (in_fire && (func == FUNC_MAP) && map_ok);
	assign km_waddr = clearing ? clr_q : waddr;
	assign km_wdata = clearing ? '0 : map_code;

	assign pm_we    = clearing || ((state_q == ST_EV) && !blocked && change);
	assign pm_waddr = clearing ? clr_q : upd_cell;
	assign pm_wdata = clearing ? 1'b0 : now_b;

	assign cur_cell = cell_of(layer_q, row_q, col_q);

	kms_ram #(
		.WIDTH (CODE_W),
		.DEPTH (CELLS)
	) u_keymap (
		.clk   (clk),
		.we    (km_we),
		.waddr (km_waddr),
		.wdata (km_wdata),
		.raddr (cur_cell),
		.rdata (rdata)
	);

	kms_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_pressed (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (cur_cell),
		.rdata (pm_rdata)
	);

	always_comb begin
		code     = rdata;
		now_b    = ~cols_q[0];
		change   = now_b != pm_rdata;
		special  = (code <= SPECIAL_MAX) || (code >= layer_key_q);
		is_layer = special && (code == layer_key_q);
		is_null  = special && (code == null_key_q) && !is_layer;
		evt      = change && !is_layer && !is_null;
		blocked  = evt && pend_q && out_busy;
		out_load = ((state_q == ST_EV) && !blocked && evt && pend_q)
			|| ((state_q == ST_FLUSH) && pend_q && !out_busy);
		out_last = (state_q == ST_FLUSH);
		new_lay  = layer_q;
		if (change && is_layer) begin
			if (now_b) begin
				if (layer_q != LAYER_W'(LAYERS - 1)) begin
					new_lay = layer_q + 1'b1;
				end
			end else begin
				if (layer_q != '0) begin
					new_lay = layer_q - 1'b1;
				end
			end
		end
		upd_cell = cell_of(new_lay, row_q, col_q);
		row_next = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
		col_last = (col_q == COL_W'(COLS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			scan_en_q   <= 1'b0;
			layer_key_q <= LAYER_KEY_RST;
			null_key_q  <= NULL_KEY_RST;
			row_q       <= '0;
			layer_q     <= '0;
			col_q       <= '0;
			cols_q      <= '0;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_SCAN_EN:   scan_en_q   <= pwdata[0];
					REG_LAYER_KEY: layer_key_q <= pwdata[CODE_W-1:0];
					REG_NULL_KEY:  null_key_q  <= pwdata[CODE_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				key_code_q  <= pcode_q;
				is_press_q  <= ppress_q;
				layer_out_q <= player_q;
				last_q      <= out_last;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire && (func == FUNC_SCAN) && scan_en_q) begin
						if (pin_word == FAIL_WORD) begin
							row_q <= row_next;
						end else begin
							cols_q  <= pin_word[COL_BASE +: COLS];
							col_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (!blocked) begin
						if (change) begin
							layer_q <= new_lay;
						end
						if (evt) begin
							pend_q   <= 1'b1;
							pcode_q  <= code;
							ppress_q <= now_b;
							player_q <= new_lay;
						end
						cols_q  <= cols_q >> 1;
						col_q   <= col_q + 1'b1;
						state_q <= col_last ? ST_FLUSH : ST_RD;
					end
				end
				ST_FLUSH: begin
					if (!(pend_q && out_busy)) begin
						pend_q  <= 1'b0;
						row_q   <= row_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_SCAN_EN:   prdata = PDATA_W'(scan_en_q);
			REG_LAYER_KEY: prdata = PDATA_W'(layer_key_q);
			REG_NULL_KEY:  prdata = PDATA_W'(null_key_q);
			default:       prdata = '0;
		endcase
	end

	assign pready    = 1'b1;
	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;
	assign is_press  = is_press_q;
	assign layer     = layer_out_q;
	assign last      = last_q;

endmodule

[tb/sv/kms_event_checker.sv]
`timescale 1ns / 1ps
module kms_event_checker
	import kms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               func,
	input  logic [PIN_W-1:0]   pin_word,
	input  logic [LAYER_W-1:0] map_layer,
	input  logic [ROW_W-1:0]   map_row,
	input  logic [COL_W-1:0]   map_col,
	input  logic [CODE_W-1:0]  map_code,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [CODE_W-1:0]  key_code,
	input  logic               is_press,
	input  logic [LAYER_W-1:0] layer,
	input  logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic               press;
		logic [LAYER_W-1:0] lay;
		logic               fin;
	} key_event_t;

	key_event_t key_events_due[$];

	logic                scan_on;
	logic [CODE_W-1:0]   layer_key;
	logic [CODE_W-1:0]   null_key;
	logic [ROW_W-1:0]    cur_row;
	logic [LAYER_W-1:0]  cur_layer;
	logic                held_keys [CELLS];
	logic [CODE_W-1:0]   key_layout [CELLS];

	function automatic int slot(input int lay, input int row, input int col);
		return (lay * ROWS + row) * COLS + col;
	endfunction

	task automatic step_row();
		if (cur_row == ROW_W'(ROWS - 1))
			cur_row = '0;
		else
			cur_row = cur_row + 1'b1;
	endtask

	task automatic scan_row(input logic [PIN_W-1:0] pins);
		logic [COLS-1:0]    col_bits;
		logic [LAYER_W-1:0] lay;
		logic               down;
		logic [CODE_W-1:0]  code;
		logic               special;
		int                 queued;
		if (int'(cur_row) >= ROWS)
			cur_row = '0;
		if (pins == FAIL_WORD) begin
			step_row();
			return;
		end
		col_bits = pins[COL_BASE +: COLS];
		queued = key_events_due.size();
		for (int c = 0; c < COLS; c++) begin
			lay = cur_layer;
			down = !col_bits[c];
			if (down != held_keys[slot(lay, cur_row, c)]) begin
				code = key_layout[slot(lay, cur_row, c)];
				special = (code <= SPECIAL_MAX) || (code >= layer_key);
				if (special && code == layer_key) begin
					if (down) begin
						if (int'(lay) < LAYERS - 1)
							lay = lay + 1'b1;
					end else if (lay != '0) begin
						lay = lay - 1'b1;
					end
					cur_layer = lay;
				end else if (!(special && code == null_key)) begin
					key_events_due.push_back('{code: code, press: down, lay: lay, fin: 1'b0});
				end
				held_keys[slot(lay, cur_row, c)] = down;
			end
		end
		if (key_events_due.size() > queued)
			key_events_due[$].fin = 1'b1;
		step_row();
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_event_t want;
		if (!arst_n) begin
			key_events_due.delete();
			scan_on = 1'b0;
			layer_key = LAYER_KEY_RST;
			null_key = NULL_KEY_RST;
			cur_row = '0;
			cur_layer = '0;
			for (int i = 0; i < CELLS; i++) begin
				held_keys[i] = 1'b0;
				key_layout[i] = '0;
			end
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SCAN_EN:   scan_on = pwdata[0];
					REG_LAYER_KEY: layer_key = pwdata[CODE_W-1:0];
					REG_NULL_KEY:  null_key = pwdata[CODE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (key_events_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected key event code=%h press=%b layer=%0d last=%b",
							$realtime, key_code, is_press, layer, last);
					fail_count++;
				end else begin
					want = key_events_due.pop_front();
					if (key_code !== want.code || is_press !== want.press ||
					    layer !== want.lay || last !== want.fin) begin
						if (fail_count < 10)
							$display({"%0t: key event mismatch: expected code=%h press=%b ",
								"layer=%0d last=%b, got code=%h press=%b layer=%0d last=%b"},
								$realtime, want.code, want.press, want.lay, want.fin,
								key_code, is_press, layer, last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_MAP) begin
					if (int'(map_layer) < LAYERS && int'(map_row) < ROWS && int'(map_col) < COLS)
						key_layout[slot(map_layer, map_row, map_col)] = map_code;
				end else if (scan_on) begin
					scan_row(pin_word);
				end
			end
			pending = key_events_due.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top
	import kms_pkg::*;
();

	localparam int   CYCLE_LIMIT = 400000;
	localparam int   DRAIN_WAIT  = 2 * (2 * COLS + 2) + 4;
	localparam int   PHASES      = 7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                func = FUNC_SCAN;
	logic [PIN_W-1:0]    pin_word = '0;
	logic [LAYER_W-1:0]  map_layer = '0;
	logic [ROW_W-1:0]    map_row = '0;
	logic [COL_W-1:0]    map_col = '0;
	logic [CODE_W-1:0]   map_code = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CODE_W-1:0]   key_code;
	logic                is_press;
	logic [LAYER_W-1:0]  layer;
	logic                last;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sent = 0;

	logic [CODE_W-1:0] layer_key = LAYER_KEY_RST;
	logic [CODE_W-1:0] null_key = NULL_KEY_RST;

	logic              scan_plan [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
	logic [CODE_W-1:0] lk_plan [PHASES] = '{8'd200, 8'd255, 8'd6, 8'd100, 8'd0, 8'd128, 8'd200};
	logic [CODE_W-1:0] nk_plan [PHASES] = '{8'd0, 8'd255, 8'd3, 8'd50, 8'd0, 8'd5, 8'd255};
	int                len_plan [PHASES] = '{50, 50, 50, 12, 50, 50, 50};

	key_matrix_scanner_with_layers dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .pin_word(pin_word), .map_layer(map_layer),
		.map_row(map_row), .map_col(map_col), .map_code(map_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_code(key_code), .is_press(is_press), .layer(layer), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	kms_event_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .pin_word(pin_word), .map_layer(map_layer),
		.map_row(map_row), .map_col(map_col), .map_code(map_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_code(key_code), .is_press(is_press), .layer(layer), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_item(
		input logic               f,
		input logic [PIN_W-1:0]   pw,
		input logic [LAYER_W-1:0] ml,
		input logic [ROW_W-1:0]   mr,
		input logic [COL_W-1:0]   mc,
		input logic [CODE_W-1:0]  code
	);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		pin_word = pw;
		map_layer = ml;
		map_row = mr;
		map_col = mc;
		map_code = code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return CODE_W'($urandom_range(255, 6));
		else if (r < 50)
			return layer_key;
		else if (r < 65)
			return null_key;
		else if (r < 80)
			return CODE_W'($urandom_range(SPECIAL_MAX));
		return CODE_W'($urandom_range(255));
	endfunction

	initial begin
		logic [COLS-1:0]  cols;
		logic [PIN_W-1:0] pw;
		int               r;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(FUNC_SCAN, 16'h0000, 2'd0, 3'd0, 3'd0, 8'h00);
		send_item(FUNC_MAP, 16'hFFFF, 2'd0, 3'd0, 3'd0, 8'h41);
		send_item(FUNC_MAP, 16'h0000, 2'd0, 3'd0, 3'd1, LAYER_KEY_RST);
		send_item(FUNC_MAP, 16'h5555, 2'd0, 3'd0, 3'd2, 8'hFF);
		send_item(FUNC_MAP, 16'hAAAA, 2'd0, 3'd0, 3'd3, SPECIAL_MAX);
		send_item(FUNC_MAP, 16'h0000, 2'd1, 3'd0, 3'd1, LAYER_KEY_RST);
		send_item(FUNC_MAP, 16'h0000, 2'd1, 3'd0, 3'd2, 8'h22);
		send_item(FUNC_MAP, 16'h0000, 2'd3, 3'd4, 3'd5, 8'h80);
		send_item(FUNC_MAP, 16'h0000, 2'd3, 3'd5, 3'd0, 8'hAA);
		send_item(FUNC_MAP, 16'h0000, 2'd2, 3'd7, 3'd7, 8'h55);
		send_item(FUNC_MAP, 16'h0000, 2'd0, 3'd0, 3'd6, 8'h11);
		settle();
		cfg_write(REG_SCAN_EN, 32'd1);

		// walk row 0 through press-all, release-all, press-all
		send_item(FUNC_SCAN, FAIL_WORD, 2'd0, 3'd0, 3'd0, 8'h00);
		for (int k = 0; k < 4; k++)
			send_item(FUNC_SCAN, (k % 2) ? 16'hFF00 : 16'h3FFF, 2'd0, 3'd0, 3'd0, 8'h00);
		send_item(FUNC_SCAN, 16'hC0FF, 2'd0, 3'd0, 3'd0, 8'h00);
		for (int k = 0; k < 4; k++)
			send_item(FUNC_SCAN, 16'h3F00, 2'd0, 3'd0, 3'd0, 8'h00);
		send_item(FUNC_SCAN, 16'h3F00, 2'd0, 3'd0, 3'd0, 8'h00);
		for (int k = 0; k < 4; k++)
			send_item(FUNC_SCAN, FAIL_WORD, 2'd0, 3'd0, 3'd0, 8'h00);
		send_item(FUNC_SCAN, 16'h0000, 2'd0, 3'd0, 3'd0, 8'h00);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			cfg_write(REG_SCAN_EN, PDATA_W'(scan_plan[ph]));
			cfg_write(REG_LAYER_KEY, PDATA_W'(lk_plan[ph]));
			cfg_write(REG_NULL_KEY, PDATA_W'(nk_plan[ph]));
			layer_key = lk_plan[ph];
			null_key = nk_plan[ph];
			for (int k = 0; k < len_plan[ph]; k++) begin
				if (sent < 130) begin
					send_idle_pct = 14;
					recv_stall_pct = 70;
				end else if (sent < 240) begin
					send_idle_pct = 70;
					recv_stall_pct = 14;
				end else begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				r = $urandom_range(99);
				if (r < 18) begin
					if ($urandom_range(99) < 85)
						send_item(FUNC_MAP, PIN_W'($urandom()),
							LAYER_W'($urandom_range(LAYERS - 1)),
							ROW_W'($urandom_range(ROWS - 1)),
							COL_W'($urandom_range(COLS - 1)), pick_code());
					else
						send_item(FUNC_MAP, PIN_W'($urandom()), LAYER_W'($urandom_range(3)),
							ROW_W'($urandom_range(7)), COL_W'($urandom_range(7)),
							CODE_W'($urandom_range(255)));
				end else begin
					if (r < 24) begin
						pw = FAIL_WORD;
					end else if (r < 28) begin
						pw = PIN_W'($urandom());
					end else begin
						for (int b = 0; b < COLS; b++)
							cols[b] = ($urandom_range(99) >= 35);
						pw = PIN_W'($urandom());
						pw[COL_BASE +: COLS] = cols;
					end
					send_item(FUNC_SCAN, pw, LAYER_W'($urandom_range(3)),
						ROW_W'($urandom_range(7)), COL_W'($urandom_range(7)),
						CODE_W'($urandom_range(255)));
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[key_matrix_scanner_with_layers.f]
design/kms_pkg.sv
design/kms_ram.sv
design/key_matrix_scanner_with_layers.sv
tb/sv/kms_event_checker.sv
tb/sv/tb_top.sv
